FILE: design/wcto_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weekday clock time offset package
// Field widths, time constants, operation codes and unit selection helpers.
// ----------------------------------------------------------------------------
package wcto_pkg;

  localparam int KindWidth   = 3;
  localparam int AmountWidth = 24;
  localparam int HourWidth   = 4;
  localparam int MinWidth    = 6;
  localparam int SecWidth    = 6;
  localparam int WdayWidth   = 3;

  // Seconds of the week fit in this many bits.
  localparam int TimeWidth = 20;
  localparam int DivWidth  = 20;
  localparam int RecWidth  = 17;
  localparam int UnitWidth = 12;

  localparam int SecsPerMin  = 60;
  localparam int SecsPerHour = 3600;
  localparam int SecsPerDay  = 86400;
  localparam int SecsPerWeek = 604800;
  localparam int MinsPerWeek = 10080;
  localparam int HoursPerWeek = 168;
  localparam int HoursPerHalf = 12;

  // Operation codes of the kind field; the two remaining codes apply no offset.
  localparam logic [KindWidth-1:0] KIND_ADD_SEC  = 3'd0;
  localparam logic [KindWidth-1:0] KIND_SUB_SEC  = 3'd1;
  localparam logic [KindWidth-1:0] KIND_ADD_MIN  = 3'd2;
  localparam logic [KindWidth-1:0] KIND_SUB_MIN  = 3'd3;
  localparam logic [KindWidth-1:0] KIND_ADD_HOUR = 3'd4;
  localparam logic [KindWidth-1:0] KIND_SUB_HOUR = 3'd5;

  typedef enum logic [1:0] {
    UNIT_NONE,
    UNIT_SEC,
    UNIT_MIN,
    UNIT_HOUR
  } unit_t;

  // The amount is reduced modulo the number of units in a week, using a
  // reciprocal scaled by two to the amount width.
  localparam logic [RecWidth-1:0] RecipWeek  = RecWidth'((2**AmountWidth) / SecsPerWeek);
  localparam logic [RecWidth-1:0] RecipMins  = RecWidth'((2**AmountWidth) / MinsPerWeek);
  localparam logic [RecWidth-1:0] RecipHours = RecWidth'((2**AmountWidth) / HoursPerWeek);

  function automatic logic [DivWidth-1:0] unit_modulus(input unit_t unit);
    logic [DivWidth-1:0] res;
    unique case (unit)
      UNIT_SEC:  res = DivWidth'(SecsPerWeek);
      UNIT_MIN:  res = DivWidth'(MinsPerWeek);
      UNIT_HOUR: res = DivWidth'(HoursPerWeek);
      default:   res = DivWidth'(HoursPerWeek);
    endcase
    return res;
  endfunction

  function automatic logic [RecWidth-1:0] unit_recip(input unit_t unit);
    logic [RecWidth-1:0] res;
    unique case (unit)
      UNIT_SEC:  res = RecipWeek;
      UNIT_MIN:  res = RecipMins;
      UNIT_HOUR: res = RecipHours;
      default:   res = RecipHours;
    endcase
    return res;
  endfunction

  function automatic logic [UnitWidth-1:0] unit_seconds(input unit_t unit);
    logic [UnitWidth-1:0] res;
    unique case (unit)
      UNIT_SEC:  res = UnitWidth'(1);
      UNIT_MIN:  res = UnitWidth'(SecsPerMin);
      UNIT_HOUR: res = UnitWidth'(SecsPerHour);
      default:   res = '0;
    endcase
    return res;
  endfunction

endpackage

FILE: design/wcto_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weekday clock time offset channels
// Valid/ready channels for the request and the adjusted time.
// ----------------------------------------------------------------------------
interface wcto_in_if;
  logic                          valid;
  logic                          ready;
  logic [wcto_pkg::KindWidth-1:0]   kind;
  logic [wcto_pkg::AmountWidth-1:0] amount;
  logic [wcto_pkg::HourWidth-1:0]   hour_in;
  logic [wcto_pkg::MinWidth-1:0]    minute_in;
  logic [wcto_pkg::SecWidth-1:0]    second_in;
  logic                          pm_in;
  logic [wcto_pkg::WdayWidth-1:0]   weekday_in;

  modport source (output valid, kind, amount, hour_in, minute_in, second_in, pm_in,
                  weekday_in, input ready);
  modport sink (input valid, kind, amount, hour_in, minute_in, second_in, pm_in,
                weekday_in, output ready);
endinterface

interface wcto_out_if;
  logic                       valid;
  logic                       ready;
  logic [wcto_pkg::HourWidth-1:0] hour_out;
  logic [wcto_pkg::MinWidth-1:0]  minute_out;
  logic [wcto_pkg::SecWidth-1:0]  second_out;
  logic                       pm_out;
  logic [wcto_pkg::WdayWidth-1:0] weekday_out;

  modport source (output valid, hour_out, minute_out, second_out, pm_out, weekday_out,
                  input ready);
  modport sink (input valid, hour_out, minute_out, second_out, pm_out, weekday_out,
                output ready);
endinterface

FILE: design/weekday_clock_time_offset.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weekday clock time offset
// Adds or subtracts seconds, minutes or hours to a twelve-hour time of week.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake     Payload
//  in_ch    in   valid/ready   kind, amount, hour_in, minute_in, second_in,
//                              pm_in, weekday_in
//  out_ch   out  valid/ready   hour_out, minute_out, second_out, pm_out, weekday_out
//
//  Ten register stages; one transfer per cycle in each direction while out_ch
//  is ready. Each stage holds about one multiply and one add or compare.
//  rst_n (synchronous, active low) empties the pipeline.
//  A stage takes new data when it is empty or the stage after it moves, so
//  bubbles close up under a stall and out_ch holds its result until taken.
// ----------------------------------------------------------------------------
module weekday_clock_time_offset (
  input  logic clk,
  input  logic rst_n,
  wcto_in_if.sink    in_ch,
  wcto_out_if.source out_ch
);
  import wcto_pkg::*;

  localparam int NumStages = 10;

  // Reciprocals used to split the time of week back into its digits.
  localparam int DayShift  = TimeWidth;
  localparam int HourShift = 17;
  localparam int MinShift  = 12;
  localparam logic [3:0] RecipDay  = 4'((2**DayShift) / SecsPerDay);
  localparam logic [5:0] RecipHour = 6'((2**HourShift) / SecsPerHour);
  localparam logic [6:0] RecipMin  = 7'((2**MinShift) / SecsPerMin);

  logic [NumStages-1:0] vld_r;
  logic [NumStages-1:0] adv;

  // A stage advances when it is empty or its successor advances.
  always_comb begin
    adv[NumStages-1] = !vld_r[NumStages-1] || out_ch.ready;
    for (int i = NumStages-2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_ch.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_ch.valid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: time of week (not yet reduced) and quotient estimate of amount.
  // --------------------------------------------------------------------------
  unit_t                  in_unit;
  logic                   in_sub;
  logic [HourWidth-1:0]   in_hmod;
  logic [4:0]             in_h24;
  logic [TimeWidth-1:0]   in_traw;
  logic [40:0]            in_qprod;

  always_comb begin
    unique case (in_ch.kind)
      KIND_ADD_SEC, KIND_SUB_SEC:   in_unit = UNIT_SEC;
      KIND_ADD_MIN, KIND_SUB_MIN:   in_unit = UNIT_MIN;
      KIND_ADD_HOUR, KIND_SUB_HOUR: in_unit = UNIT_HOUR;
      default:                      in_unit = UNIT_NONE;
    endcase
    in_sub = (in_ch.kind == KIND_SUB_SEC) || (in_ch.kind == KIND_SUB_MIN) ||
             (in_ch.kind == KIND_SUB_HOUR);
    in_hmod = (in_ch.hour_in >= HourWidth'(HoursPerHalf)) ?
              in_ch.hour_in - HourWidth'(HoursPerHalf) : in_ch.hour_in;
    in_h24 = 5'(in_hmod) + (in_ch.pm_in ? 5'(HoursPerHalf) : 5'd0);
    in_traw = TimeWidth'(in_ch.weekday_in) * TimeWidth'(SecsPerDay)
            + TimeWidth'(in_h24) * TimeWidth'(SecsPerHour)
            + TimeWidth'(in_ch.minute_in) * TimeWidth'(SecsPerMin)
            + TimeWidth'(in_ch.second_in);
    in_qprod = 41'(in_ch.amount) * 41'(unit_recip(in_unit));
  end

  logic [TimeWidth-1:0]   s1_traw_r;
  logic [AmountWidth-1:0] s1_amount_r;
  logic [RecWidth-1:0]    s1_qe_r;
  unit_t                  s1_unit_r;
  logic                   s1_sub_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_traw_r   <= in_traw;
      s1_amount_r <= in_ch.amount;
      s1_qe_r     <= in_qprod[AmountWidth+RecWidth-1:AmountWidth];
      s1_unit_r   <= in_unit;
      s1_sub_r    <= in_sub;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: reduce the time modulo a week, partial remainder of the amount.
  // --------------------------------------------------------------------------
  logic [36:0] s1_qc;
  logic [36:0] s1_rem;

  assign s1_qc  = 37'(s1_qe_r) * 37'(unit_modulus(s1_unit_r));
  assign s1_rem = 37'(s1_amount_r) - s1_qc;

  logic [TimeWidth-1:0] s2_t_r;
  logic [DivWidth:0]    s2_r0_r;
  unit_t                s2_unit_r;
  logic                 s2_sub_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_t_r    <= (s1_traw_r >= TimeWidth'(SecsPerWeek)) ?
                   s1_traw_r - TimeWidth'(SecsPerWeek) : s1_traw_r;
      s2_r0_r   <= s1_rem[DivWidth:0];
      s2_unit_r <= s1_unit_r;
      s2_sub_r  <= s1_sub_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: final amount remainder, scaled to seconds of offset.
  // --------------------------------------------------------------------------
  logic [DivWidth:0]   s2_mod;
  logic [DivWidth:0]   s2_r;
  logic [31:0]         s2_off;

  always_comb begin
    s2_mod = {1'b0, unit_modulus(s2_unit_r)};
    s2_r   = (s2_r0_r >= s2_mod) ? s2_r0_r - s2_mod : s2_r0_r;
    s2_off = 32'(s2_r[DivWidth-1:0]) * 32'(unit_seconds(s2_unit_r));
  end

  logic [TimeWidth-1:0] s3_t_r;
  logic [TimeWidth-1:0] s3_off_r;
  logic                 s3_sub_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_t_r   <= s2_t_r;
      s3_off_r <= s2_off[TimeWidth-1:0];
      s3_sub_r <= s2_sub_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: apply the offset modulo one week.
  // --------------------------------------------------------------------------
  logic [TimeWidth:0] s3_sum;
  logic [TimeWidth:0] s3_wrap;

  always_comb begin
    s3_sum = s3_sub_r ?
             {1'b0, s3_t_r} + ((TimeWidth+1)'(SecsPerWeek) - {1'b0, s3_off_r}) :
             {1'b0, s3_t_r} + {1'b0, s3_off_r};
    s3_wrap = (s3_sum >= (TimeWidth+1)'(SecsPerWeek)) ?
              s3_sum - (TimeWidth+1)'(SecsPerWeek) : s3_sum;
  end

  logic [TimeWidth-1:0] s4_t_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_t_r <= s3_wrap[TimeWidth-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stages 5 and 6: weekday and second of the day.
  // --------------------------------------------------------------------------
  logic [TimeWidth+3:0] s4_qprod;

  assign s4_qprod = (TimeWidth+4)'(s4_t_r) * (TimeWidth+4)'(RecipDay);

  logic [TimeWidth-1:0] s5_t_r;
  logic [WdayWidth-1:0] s5_qd_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_t_r  <= s4_t_r;
      s5_qd_r <= s4_qprod[DayShift+WdayWidth-1:DayShift];
    end
  end

  logic [TimeWidth-1:0] s5_rd0;
  logic                 s5_fix;

  always_comb begin
    s5_rd0 = s5_t_r - TimeWidth'(s5_qd_r) * TimeWidth'(SecsPerDay);
    s5_fix = (s5_rd0 >= TimeWidth'(SecsPerDay));
  end

  logic [WdayWidth-1:0] s6_wday_r;
  logic [16:0]          s6_rday_r;
  logic [TimeWidth-1:0] s5_rday;

  assign s5_rday = s5_fix ? s5_rd0 - TimeWidth'(SecsPerDay) : s5_rd0;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s6_wday_r <= s5_fix ? s5_qd_r + WdayWidth'(1) : s5_qd_r;
      s6_rday_r <= s5_rday[16:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stages 7 and 8: hour of the day and second of the hour.
  // --------------------------------------------------------------------------
  logic [22:0] s6_qprod;

  assign s6_qprod = 23'(s6_rday_r) * 23'(RecipHour);

  logic [WdayWidth-1:0] s7_wday_r;
  logic [16:0]          s7_rday_r;
  logic [4:0]           s7_qh_r;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s7_wday_r <= s6_wday_r;
      s7_rday_r <= s6_rday_r;
      s7_qh_r   <= s6_qprod[HourShift+4:HourShift];
    end
  end

  logic [16:0] s7_rh0;
  logic [16:0] s7_rh;
  logic        s7_fix;

  always_comb begin
    s7_rh0 = s7_rday_r - 17'(s7_qh_r) * 17'(SecsPerHour);
    s7_fix = (s7_rh0 >= 17'(SecsPerHour));
    s7_rh  = s7_fix ? s7_rh0 - 17'(SecsPerHour) : s7_rh0;
  end

  logic [WdayWidth-1:0] s8_wday_r;
  logic [4:0]           s8_h24_r;
  logic [11:0]          s8_rh_r;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s8_wday_r <= s7_wday_r;
      s8_h24_r  <= s7_fix ? s7_qh_r + 5'd1 : s7_qh_r;
      s8_rh_r   <= s7_rh[11:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stages 9 and 10: minute and second, then the twelve-hour dial.
  // --------------------------------------------------------------------------
  logic [18:0] s8_qprod;

  assign s8_qprod = 19'(s8_rh_r) * 19'(RecipMin);

  logic [WdayWidth-1:0] s9_wday_r;
  logic [4:0]           s9_h24_r;
  logic [11:0]          s9_rh_r;
  logic [MinWidth-1:0]  s9_qm_r;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s9_wday_r <= s8_wday_r;
      s9_h24_r  <= s8_h24_r;
      s9_rh_r   <= s8_rh_r;
      s9_qm_r   <= s8_qprod[MinShift+MinWidth-1:MinShift];
    end
  end

  logic [11:0]          s9_rm0;
  logic [11:0]          s9_rm;
  logic                 s9_fix;
  logic                 s9_pm;
  logic [4:0]           s9_h12;

  always_comb begin
    s9_rm0 = s9_rh_r - 12'(s9_qm_r) * 12'(SecsPerMin);
    s9_fix = (s9_rm0 >= 12'(SecsPerMin));
    s9_rm  = s9_fix ? s9_rm0 - 12'(SecsPerMin) : s9_rm0;
    s9_pm  = (s9_h24_r >= 5'(HoursPerHalf));
    s9_h12 = s9_pm ? s9_h24_r - 5'(HoursPerHalf) : s9_h24_r;
    // Hour zero of either half day shows as twelve on the dial.
    if (s9_h12 == 5'd0) begin
      s9_h12 = 5'(HoursPerHalf);
    end
  end

  logic [HourWidth-1:0] s10_hour_r;
  logic [MinWidth-1:0]  s10_min_r;
  logic [SecWidth-1:0]  s10_sec_r;
  logic                 s10_pm_r;
  logic [WdayWidth-1:0] s10_wday_r;

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      s10_hour_r <= s9_h12[HourWidth-1:0];
      s10_min_r  <= s9_fix ? s9_qm_r + MinWidth'(1) : s9_qm_r;
      s10_sec_r  <= s9_rm[SecWidth-1:0];
      s10_pm_r   <= s9_pm;
      s10_wday_r <= s9_wday_r;
    end
  end

  assign out_ch.valid       = vld_r[NumStages-1];
  assign out_ch.hour_out    = s10_hour_r;
  assign out_ch.minute_out  = s10_min_r;
  assign out_ch.second_out  = s10_sec_r;
  assign out_ch.pm_out      = s10_pm_r;
  assign out_ch.weekday_out = s10_wday_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> (s3_off_r < TimeWidth'(SecsPerWeek)))
    else $error("offset not reduced below one week");

  a_week_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> (s4_t_r < TimeWidth'(SecsPerWeek)))
    else $error("adjusted time outside one week");

  a_day_split: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] |-> (s6_wday_r < WdayWidth'(7)) && (s6_rday_r < 17'(SecsPerDay)))
    else $error("weekday split out of range");

  a_dial_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.hour_out >= HourWidth'(1)) &&
                     (out_ch.hour_out <= HourWidth'(HoursPerHalf)) &&
                     (out_ch.minute_out < MinWidth'(SecsPerMin)) &&
                     (out_ch.second_out < SecWidth'(SecsPerMin)))
    else $error("result outside the twelve-hour dial");

  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] && !adv[4] |=> vld_r[4] && $stable(s5_t_r))
    else $error("stalled stage lost its item");

endmodule

FILE: tb/time_offset_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weekday clock time offset checker
// Watches both channels, predicts the adjusted time of every request taken by
// the block and compares each returned time field by field, in order.
// ----------------------------------------------------------------------------
module time_offset_checker (
  input  logic        clk,
  input  logic        rst_n,
  wcto_in_if          in_mon,
  wcto_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned awaited
);
  import wcto_pkg::*;

  localparam int PrintCap = 60;

  typedef struct packed {
    logic [HourWidth-1:0] hour;
    logic [MinWidth-1:0]  minute;
    logic [SecWidth-1:0]  second;
    logic                 pm;
    logic [WdayWidth-1:0] weekday;
  } dial_time_t;

  dial_time_t due_times[$];

  initial begin
    fail_count = 0;
    awaited    = 0;
  end

  // Converts the dial time to seconds of the week, applies the offset modulo
  // one week and converts back.
  function automatic dial_time_t shifted_time(
    input logic [KindWidth-1:0]   kind,
    input logic [AmountWidth-1:0] amount,
    input logic [HourWidth-1:0]   hour,
    input logic [MinWidth-1:0]    minute,
    input logic [SecWidth-1:0]    second,
    input logic                   pm,
    input logic [WdayWidth-1:0]   weekday
  );
    longint unsigned week_sec;
    longint unsigned unit_sec;
    longint unsigned shift;
    longint unsigned day_sec;
    longint unsigned h24;
    dial_time_t      res;
    week_sec = longint'(weekday) * SecsPerDay
             + (longint'(hour) % HoursPerHalf + HoursPerHalf * longint'(pm)) * SecsPerHour
             + longint'(minute) * SecsPerMin + longint'(second);
    week_sec = week_sec % SecsPerWeek;
    case (kind)
      KIND_ADD_SEC, KIND_SUB_SEC:   unit_sec = 1;
      KIND_ADD_MIN, KIND_SUB_MIN:   unit_sec = SecsPerMin;
      KIND_ADD_HOUR, KIND_SUB_HOUR: unit_sec = SecsPerHour;
      default:                      unit_sec = 0;
    endcase
    shift = (longint'(amount) * unit_sec) % SecsPerWeek;
    if (kind == KIND_SUB_SEC || kind == KIND_SUB_MIN || kind == KIND_SUB_HOUR) begin
      week_sec = (week_sec + SecsPerWeek - shift) % SecsPerWeek;
    end else begin
      week_sec = (week_sec + shift) % SecsPerWeek;
    end
    day_sec     = week_sec % SecsPerDay;
    h24         = day_sec / SecsPerHour;
    res.hour    = (h24 % HoursPerHalf == 0) ? HourWidth'(HoursPerHalf)
                                             : HourWidth'(h24 % HoursPerHalf);
    res.minute  = MinWidth'((day_sec % SecsPerHour) / SecsPerMin);
    res.second  = SecWidth'(day_sec % SecsPerMin);
    res.pm      = (h24 >= HoursPerHalf);
    res.weekday = WdayWidth'(week_sec / SecsPerDay);
    return res;
  endfunction

  task automatic report(input string what, input int got, input int want);
    if (fail_count < PrintCap) begin
      $display("tb: mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    dial_time_t want;
    if (!rst_n) begin
      due_times.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (due_times.size() == 0) begin
          report("result with no request waiting, hour", out_mon.hour_out, 0);
        end else begin
          want = due_times.pop_front();
          if (out_mon.hour_out !== want.hour) report("hour", out_mon.hour_out, want.hour);
          if (out_mon.minute_out !== want.minute) begin
            report("minute", out_mon.minute_out, want.minute);
          end
          if (out_mon.second_out !== want.second) begin
            report("second", out_mon.second_out, want.second);
          end
          if (out_mon.pm_out !== want.pm) report("pm", out_mon.pm_out, want.pm);
          if (out_mon.weekday_out !== want.weekday) begin
            report("weekday", out_mon.weekday_out, want.weekday);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        due_times.push_back(shifted_time(in_mon.kind, in_mon.amount, in_mon.hour_in,
                                         in_mon.minute_in, in_mon.second_in, in_mon.pm_in,
                                         in_mon.weekday_in));
      end
    end
    awaited <= due_times.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weekday clock time offset testbench
// Sends directed corner requests and then random ones through the block with
// random gaps and output stalls; a checker beside the block predicts and
// compares every returned time.
// ----------------------------------------------------------------------------
module tb;
  import wcto_pkg::*;

  localparam logic [KindWidth-1:0] KIND_NOP_A = 3'd6;
  localparam logic [KindWidth-1:0] KIND_NOP_B = 3'd7;

  localparam int RandomItems = 630;
  localparam int CalmItems   = 100;
  localparam int QuietLimit  = 1000;
  localparam int DrainCycles = 25;

  logic        clk;
  logic        rst_n;
  logic        gaps_on;
  int unsigned fail_count;
  int unsigned awaited;
  int unsigned quiet_cycles;

  wcto_in_if  in_ch ();
  wcto_out_if out_ch ();

  weekday_clock_time_offset uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  time_offset_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .awaited    (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Presents one request, at times with a random gap ahead of it while gaps are
  // on, and returns after its transfer.
  task automatic send_request(
    input logic [KindWidth-1:0]   kind,
    input logic [AmountWidth-1:0] amount,
    input logic [HourWidth-1:0]   hour,
    input logic [MinWidth-1:0]    minute,
    input logic [SecWidth-1:0]    second,
    input logic                   pm,
    input logic [WdayWidth-1:0]   weekday
  );
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.amount     <= amount;
    in_ch.hour_in    <= hour;
    in_ch.minute_in  <= minute;
    in_ch.second_in  <= second;
    in_ch.pm_in      <= pm;
    in_ch.weekday_in <= weekday;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  // Result side: random stall bursts between stretches of readiness.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (gaps_on && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // Ends the run if nothing moves on either channel for too long.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [KindWidth-1:0]   kind;
    logic [AmountWidth-1:0] amount;
    logic [HourWidth-1:0]   hour;
    logic [MinWidth-1:0]    minute;
    logic [SecWidth-1:0]    second;
    logic                   pm;
    logic [WdayWidth-1:0]   weekday;
    gaps_on          = 1'b1;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_ADD_SEC;
    in_ch.amount     <= '0;
    in_ch.hour_in    <= '0;
    in_ch.minute_in  <= '0;
    in_ch.second_in  <= '0;
    in_ch.pm_in      <= 1'b0;
    in_ch.weekday_in <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Week boundaries in both directions.
    send_request(KIND_SUB_SEC, 24'd1, 4'd12, 6'd0, 6'd0, 1'b0, 3'd0);
    send_request(KIND_ADD_SEC, 24'd1, 4'd11, 6'd59, 6'd59, 1'b1, 3'd6);
    send_request(KIND_ADD_MIN, 24'd0, 4'd7, 6'd30, 6'd15, 1'b0, 3'd3);
    // Largest amount with every operation.
    send_request(KIND_ADD_SEC, 24'hFFFFFF, 4'd1, 6'd2, 6'd3, 1'b0, 3'd1);
    send_request(KIND_SUB_SEC, 24'hFFFFFF, 4'd1, 6'd2, 6'd3, 1'b1, 3'd2);
    send_request(KIND_ADD_MIN, 24'hFFFFFF, 4'd12, 6'd59, 6'd0, 1'b0, 3'd4);
    send_request(KIND_SUB_MIN, 24'hFFFFFF, 4'd12, 6'd0, 6'd59, 1'b1, 3'd5);
    send_request(KIND_ADD_HOUR, 24'hFFFFFF, 4'd6, 6'd45, 6'd10, 1'b0, 3'd6);
    send_request(KIND_SUB_HOUR, 24'hFFFFFF, 4'd6, 6'd45, 6'd10, 1'b1, 3'd0);
    // Exactly one week in each unit leaves the time unchanged.
    send_request(KIND_ADD_SEC, 24'd604800, 4'd3, 6'd4, 6'd5, 1'b1, 3'd2);
    send_request(KIND_SUB_MIN, 24'd10080, 4'd3, 6'd4, 6'd5, 1'b0, 3'd2);
    send_request(KIND_ADD_HOUR, 24'd168, 4'd3, 6'd4, 6'd5, 1'b1, 3'd2);
    // Crossing noon and midnight by hours.
    send_request(KIND_ADD_HOUR, 24'd1, 4'd11, 6'd20, 6'd0, 1'b0, 3'd3);
    send_request(KIND_SUB_HOUR, 24'd1, 4'd12, 6'd20, 6'd0, 1'b1, 3'd3);
    send_request(KIND_SUB_HOUR, 24'd13, 4'd12, 6'd0, 6'd0, 1'b0, 3'd1);
    // Unknown operations return the normalized time, fields past their range.
    send_request(KIND_NOP_A, 24'hFFFFFF, 4'd15, 6'd63, 6'd63, 1'b1, 3'd7);
    send_request(KIND_NOP_B, 24'd12345, 4'd0, 6'd0, 6'd0, 1'b0, 3'd0);
    // Hour zero and hours past the dial, minute and second overflow, weekday 7.
    send_request(KIND_ADD_SEC, 24'd0, 4'd0, 6'd60, 6'd60, 1'b1, 3'd6);
    send_request(KIND_ADD_MIN, 24'd1, 4'd13, 6'd63, 6'd0, 1'b0, 3'd7);
    send_request(KIND_SUB_SEC, 24'd61, 4'd14, 6'd0, 6'd63, 1'b1, 3'd7);
    send_request(KIND_SUB_MIN, 24'd59, 4'd15, 6'd1, 6'd1, 1'b0, 3'd5);
    drain_results();

    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 2) drain_results();
      if (i == RandomItems - CalmItems) gaps_on = 1'b0;
      if ($urandom_range(0, 15) == 0) begin
        kind = ($urandom_range(0, 1) == 0) ? KIND_NOP_A : KIND_NOP_B;
      end else begin
        kind = KindWidth'($urandom_range(0, 5));
      end
      case ($urandom_range(0, 5))
        0: amount = AmountWidth'($urandom_range(0, 120));
        1: amount = AmountWidth'($urandom_range(0, 2 * MinsPerWeek));
        2: amount = AmountWidth'($urandom_range(1, 27) * SecsPerWeek
                                 + $urandom_range(0, 4) - 2);
        3: amount = AmountWidth'($urandom_range(0, SecsPerWeek));
        4: amount = AmountWidth'((1 << AmountWidth) - 1 - $urandom_range(0, 300));
        default: amount = AmountWidth'($urandom);
      endcase
      if ($urandom_range(0, 9) != 0) begin
        hour    = HourWidth'($urandom_range(1, 12));
        minute  = MinWidth'($urandom_range(0, 59));
        second  = SecWidth'($urandom_range(0, 59));
        weekday = WdayWidth'($urandom_range(0, 6));
      end else begin
        hour    = HourWidth'($urandom);
        minute  = MinWidth'($urandom);
        second  = SecWidth'($urandom);
        weekday = WdayWidth'($urandom);
      end
      pm = 1'($urandom);
      send_request(kind, amount, hour, minute, second, pm, weekday);
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && awaited == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
